// ----- rtl/core/two_way_data_cache_controller_macros.svh -----
// Assertion macros for the cache controller RTL.
`ifndef TWO_WAY_DATA_CACHE_CONTROLLER_MACROS_SVH
`define TWO_WAY_DATA_CACHE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must never hold outside reset.
`define TWDCC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Implication checked at every clock edge outside reset.
`define TWDCC_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`else

`define TWDCC_ASSERT_NEVER(lbl, cond, msg)
`define TWDCC_ASSERT_PROP(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/twdcc_pkg.sv -----
// Shared types and constants of the two-way data cache controller.
package twdcc_pkg;

  // Fixed field widths of the transaction ports and the dirty queue depth
  localparam int unsigned ADDR_BITS   = 28;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QCNT_W      = 6;
  localparam int unsigned QUEUE_DEPTH = 32;

  // Defaults for the top-level geometry parameters (powers of two)
  localparam int unsigned SET_COUNT_DEF      = 256;
  localparam int unsigned WORDS_PER_LINE_DEF = 8;

  // Transaction opcodes
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_W-1:0]    data;
    logic                 fill_last;
    logic                 bus_read_ack;
  } cache_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic                 read_valid;
    logic                 fetching;
    logic [ADDR_BITS-1:0] bus_read_address;
    logic                 bus_read_request;
    logic [QCNT_W-1:0]    queue_count;
    logic                 queue_overflow;
  } cache_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // tag store clearing sweep
    logic accept;  // capture the incoming transaction
    logic eval;    // lookup data valid, update state
  } twdcc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } twdcc_sts_t;

endpackage

// ----- rtl/core/twdcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module twdcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/twdcc_ctrl.sv -----
// Sequencing state machine of the cache controller.
module twdcc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  output logic                   done_o,
  input  twdcc_pkg::twdcc_sts_t  sts_i,
  output twdcc_pkg::twdcc_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.accept = (state_q == ST_IDLE) && start_i;
  assign cmd_o.eval   = (state_q == ST_EVAL);
  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;

endmodule

// ----- rtl/core/twdcc_dp.sv -----
// Datapath: tag store, data ways, lookup and status registers.
module twdcc_dp #(
  parameter int unsigned SET_COUNT      = twdcc_pkg::SET_COUNT_DEF,
  parameter int unsigned WORDS_PER_LINE = twdcc_pkg::WORDS_PER_LINE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  twdcc_pkg::twdcc_cmd_t  cmd_i,
  output twdcc_pkg::twdcc_sts_t  sts_o,
  input  twdcc_pkg::cache_req_t  req_i,
  output twdcc_pkg::cache_rsp_t  rsp_o
);

  localparam int unsigned AB     = twdcc_pkg::ADDR_BITS;
  localparam int unsigned DW     = twdcc_pkg::DATA_W;
  localparam int unsigned CW     = twdcc_pkg::QCNT_W;
  localparam int unsigned SET_W  = $clog2(SET_COUNT);
  localparam int unsigned WORD_W = $clog2(WORDS_PER_LINE);
  localparam int unsigned OFF_W  = WORD_W + 2;
  localparam int unsigned IDX_W  = SET_W + WORD_W;
  localparam int unsigned TAG_W  = AB - OFF_W - SET_W;
  localparam int unsigned DEPTH  = SET_COUNT * WORDS_PER_LINE;

  // One tag store row holds both ways of a set
  typedef struct packed {
    logic [TAG_W-1:0] tag1;
    logic [TAG_W-1:0] tag0;
    logic             valid1;
    logic             valid0;
    logic             dq1;
    logic             dq0;
    logic             recent;
  } set_entry_t;

  localparam int unsigned ENT_W = $bits(set_entry_t);

  twdcc_pkg::cache_req_t req_q;
  logic [SET_W-1:0]      clr_idx_q;

  set_entry_t            ent_rd, ent_new, ent_wdata;
  logic                  ent_upd, ent_we;
  logic [SET_W-1:0]      ent_waddr;
  logic [DW-1:0]         d0_rd, d1_rd;
  logic                  dwe0, dwe1;

  logic [SET_W-1:0]      set_idx;
  logic [IDX_W-1:0]      data_idx;
  logic [TAG_W-1:0]      tag;
  logic                  hit0, hit1, way;

  logic [DW-1:0]         read_word_q, read_word_d;
  logic                  read_ok_q, read_ok_d;
  logic                  fetch_q, fetch_d;
  logic                  victim_q, victim_d;
  logic [AB-1:0]         req_addr_q, req_addr_d;
  logic                  pending_q, pending_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  overflow_q, overflow_d;

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
  end

  // Clearing sweep over the tag store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clear) begin
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  assign sts_o.clear_last = &clr_idx_q;

  // Address split of the captured transaction
  assign set_idx  = req_q.address[OFF_W +: SET_W];
  assign data_idx = req_q.address[2 +: IDX_W];
  assign tag      = req_q.address[AB-1 -: TAG_W];
  assign hit0     = ent_rd.valid0 && (ent_rd.tag0 == tag);
  assign hit1     = ent_rd.valid1 && (ent_rd.tag1 == tag);
  assign way      = !hit0;

  // Lookup and update
  always_comb begin
    ent_new     = ent_rd;
    ent_upd     = 1'b0;
    dwe0        = 1'b0;
    dwe1        = 1'b0;
    read_word_d = read_word_q;
    read_ok_d   = read_ok_q;
    fetch_d     = fetch_q;
    victim_d    = victim_q;
    req_addr_d  = req_addr_q;
    pending_d   = req_q.bus_read_ack ? 1'b0 : pending_q;
    count_d     = count_q;
    overflow_d  = 1'b0;

    if (fetch_q) begin
      // Fill word goes to the victim way; last word installs the line
      if (req_q.opcode == twdcc_pkg::OP_FILL) begin
        dwe0 = !victim_q;
        dwe1 = victim_q;
        if (req_q.fill_last) begin
          if (victim_q) begin
            ent_new.tag1   = tag;
            ent_new.valid1 = 1'b1;
            ent_new.dq1    = 1'b0;
          end else begin
            ent_new.tag0   = tag;
            ent_new.valid0 = 1'b1;
            ent_new.dq0    = 1'b0;
          end
          ent_new.recent = victim_q;
          ent_upd        = 1'b1;
          fetch_d        = 1'b0;
        end
      end
    end else if ((req_q.opcode == twdcc_pkg::OP_READ) ||
                 (req_q.opcode == twdcc_pkg::OP_WRITE)) begin
      if (!hit0 && !hit1) begin
        // Miss: request the aligned line, replace the LRU way
        victim_d   = !ent_rd.recent;
        req_addr_d = {req_q.address[AB-1:OFF_W], {OFF_W{1'b0}}};
        pending_d  = 1'b1;
        read_ok_d  = 1'b0;
        fetch_d    = 1'b1;
      end else begin
        ent_new.recent = way;
        ent_upd        = 1'b1;
        if (req_q.opcode == twdcc_pkg::OP_READ) begin
          read_word_d = way ? d1_rd : d0_rd;
          read_ok_d   = 1'b1;
        end else begin
          dwe0 = !way;
          dwe1 = way;
          // Count each dirty line once in the dirty queue
          if (!(way ? ent_rd.dq1 : ent_rd.dq0)) begin
            if (count_q < CW'(twdcc_pkg::QUEUE_DEPTH)) begin
              count_d = count_q + 1'b1;
              if (way) begin
                ent_new.dq1 = 1'b1;
              end else begin
                ent_new.dq0 = 1'b1;
              end
            end else begin
              overflow_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // Status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_word_q <= '0;
      read_ok_q   <= 1'b0;
      fetch_q     <= 1'b0;
      victim_q    <= 1'b0;
      req_addr_q  <= '0;
      pending_q   <= 1'b0;
      count_q     <= '0;
      overflow_q  <= 1'b0;
    end else if (cmd_i.eval) begin
      read_word_q <= read_word_d;
      read_ok_q   <= read_ok_d;
      fetch_q     <= fetch_d;
      victim_q    <= victim_d;
      req_addr_q  <= req_addr_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
    end
  end

  // Tag store write: clearing sweep or row update
  assign ent_we    = cmd_i.clear || (cmd_i.eval && ent_upd);
  assign ent_waddr = cmd_i.clear ? clr_idx_q : set_idx;
  assign ent_wdata = cmd_i.clear ? set_entry_t'('0) : ent_new;

  twdcc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SET_COUNT)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (req_i.address[OFF_W +: SET_W]),
    .rdata_o (ent_rd)
  );

  twdcc_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_way0_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.eval && dwe0),
    .waddr_i (data_idx),
    .wdata_i (req_q.data),
    .raddr_i (req_i.address[2 +: IDX_W]),
    .rdata_o (d0_rd)
  );

  twdcc_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_way1_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.eval && dwe1),
    .waddr_i (data_idx),
    .wdata_i (req_q.data),
    .raddr_i (req_i.address[2 +: IDX_W]),
    .rdata_o (d1_rd)
  );

  assign rsp_o.read_data        = read_word_q;
  assign rsp_o.read_valid       = read_ok_q;
  assign rsp_o.fetching         = fetch_q;
  assign rsp_o.bus_read_address = req_addr_q;
  assign rsp_o.bus_read_request = pending_q;
  assign rsp_o.queue_count      = count_q;
  assign rsp_o.queue_overflow   = overflow_q;

endmodule

// ----- rtl/core/two_way_data_cache_controller.sv -----
// Top level of the two-way set-associative data cache controller.
//
//  channel   handshake             payload
//  --------  --------------------  ---------------------------------
//  request   start_i && !busy_o    req_i  (twdcc_pkg::cache_req_t)
//  result    rsp_valid_o, 1 cycle  rsp_o  (twdcc_pkg::cache_rsp_t)
//
// Every transaction is a registered read of the tag store and both data
// ways, then a tag compare and write back. The result is strobed in the
// cycle after that, while the next transaction may already be accepted;
// no new transaction is taken until the last one has been evaluated.
// After reset the tag store is swept, one set per cycle, and busy_o stays
// high until every set is cleared. The result side has no back-pressure.
`include "two_way_data_cache_controller_macros.svh"

module two_way_data_cache_controller #(
  parameter int unsigned SET_COUNT      = twdcc_pkg::SET_COUNT_DEF,
  parameter int unsigned WORDS_PER_LINE = twdcc_pkg::WORDS_PER_LINE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  twdcc_pkg::cache_req_t req_i,
  output logic                  rsp_valid_o,
  output twdcc_pkg::cache_rsp_t rsp_o
);

  localparam int unsigned OFF_W = $clog2(WORDS_PER_LINE) + 2;

  twdcc_pkg::twdcc_cmd_t cmd;
  twdcc_pkg::twdcc_sts_t sts;

  twdcc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (rsp_valid_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  twdcc_dp #(
    .SET_COUNT      (SET_COUNT),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  // Results only come from an accepted transaction, through the evaluation state
  `TWDCC_ASSERT_PROP(a_rsp_follows_accept, rsp_valid_o |-> $past(start_i && !busy_o, 2),
                     "result strobe without accepted transaction")

  // An accepted transaction blocks the next cycle
  `TWDCC_ASSERT_PROP(a_busy_after_accept, (start_i && !busy_o) |=> busy_o,
                     "accepted transaction did not raise busy")

  // Dirty queue never exceeds its depth
  `TWDCC_ASSERT_NEVER(a_queue_bound,
                      rsp_o.queue_count > twdcc_pkg::QCNT_W'(twdcc_pkg::QUEUE_DEPTH),
                      "dirty queue count above depth")

  // Line requests are aligned and an overflow only comes from a write hit
  `TWDCC_ASSERT_NEVER(a_line_aligned,
                      (rsp_o.bus_read_address[OFF_W-1:0] != '0) ||
                      (rsp_o.queue_overflow && rsp_o.fetching),
                      "misaligned line request or overflow during fill")

endmodule

// ----- tb/sv/two_way_data_cache_controller_checker.sv -----
// Result checker for the two-way data cache controller: predicts every response and compares it.
`timescale 1ns / 100ps

module two_way_data_cache_controller_checker
  import twdcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  cache_req_t  req_i,
  input  logic        rsp_valid_i,
  input  cache_rsp_t  rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned SETS   = SET_COUNT_DEF;
  localparam int unsigned WORDS  = WORDS_PER_LINE_DEF;
  localparam int unsigned WORD_W = $clog2(WORDS);
  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned LINE_W = WORD_W + 2;
  localparam int unsigned TAG_W  = ADDR_BITS - LINE_W - SET_W;

  // Shadow copy of the cache contents and control state
  logic [DATA_W-1:0]    line_data   [2][SETS*WORDS];
  logic [TAG_W-1:0]     line_tag    [2][SETS];
  bit                   line_valid  [2][SETS];
  bit                   line_queued [2][SETS];
  bit                   set_mru     [SETS];
  bit                   fill_way;
  bit                   filling;
  bit                   hit_seen;
  bit                   request_up;
  logic [DATA_W-1:0]    hit_word;
  logic [ADDR_BITS-1:0] request_line;
  int unsigned          dirty_lines;

  cache_rsp_t expected_rsp_q [$];
  cache_rsp_t want_rsp;

  // Apply one accepted transaction to the shadow state, return the response it causes
  function automatic cache_rsp_t predict_cache_response(input cache_req_t r);
    cache_rsp_t        p;
    logic [SET_W-1:0]  s;
    logic [WORD_W-1:0] w;
    logic [TAG_W-1:0]  t;
    bit                way;
    bit                hit;
    bit                dropped;
    s       = r.address[LINE_W +: SET_W];
    w       = r.address[2 +: WORD_W];
    t       = r.address[ADDR_BITS-1 -: TAG_W];
    way     = 1'b0;
    hit     = 1'b1;
    dropped = 1'b0;
    // ack clears first; a miss in the same transaction raises it again
    if (r.bus_read_ack) request_up = 1'b0;
    if (filling) begin
      if (r.opcode == OP_FILL) begin
        line_data[fill_way][{s, w}] = r.data;
        if (r.fill_last) begin
          line_tag[fill_way][s]    = t;
          line_valid[fill_way][s]  = 1'b1;
          line_queued[fill_way][s] = 1'b0;
          set_mru[s]               = fill_way;
          filling                  = 1'b0;
        end
      end
    end else if (r.opcode == OP_READ || r.opcode == OP_WRITE) begin
      // way 0 wins when both ways hold the tag
      if (line_valid[0][s] && line_tag[0][s] == t) begin
        way = 1'b0;
      end else if (line_valid[1][s] && line_tag[1][s] == t) begin
        way = 1'b1;
      end else begin
        hit = 1'b0;
      end
      if (!hit) begin
        fill_way     = !set_mru[s];
        request_line = {r.address[ADDR_BITS-1:LINE_W], {LINE_W{1'b0}}};
        request_up   = 1'b1;
        hit_seen     = 1'b0;
        filling      = 1'b1;
      end else begin
        set_mru[s] = way;
        if (r.opcode == OP_READ) begin
          hit_word = line_data[way][{s, w}];
          hit_seen = 1'b1;
        end else begin
          line_data[way][{s, w}] = r.data;
          // one queue entry per dirty line; a full queue drops it
          if (!line_queued[way][s]) begin
            if (dirty_lines < QUEUE_DEPTH) begin
              dirty_lines++;
              line_queued[way][s] = 1'b1;
            end else begin
              dropped = 1'b1;
            end
          end
        end
      end
    end
    p.read_data        = hit_word;
    p.read_valid       = hit_seen;
    p.fetching         = filling;
    p.bus_read_address = request_line;
    p.bus_read_request = request_up;
    p.queue_count      = dirty_lines[QCNT_W-1:0];
    p.queue_overflow   = dropped;
    return p;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  // Check responses against the oldest prediction, then record new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SETS; i++) begin
        for (int k = 0; k < 2; k++) begin
          line_tag[k][i]    = '0;
          line_valid[k][i]  = 1'b0;
          line_queued[k][i] = 1'b0;
        end
        set_mru[i] = 1'b0;
      end
      fill_way     = 1'b0;
      filling      = 1'b0;
      hit_seen     = 1'b0;
      request_up   = 1'b0;
      hit_word     = '0;
      request_line = '0;
      dirty_lines  = 0;
      expected_rsp_q.delete();
      pending_o    = 0;
    end else begin
      if (rsp_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response strobed with no transaction outstanding");
          fail_count_o++;
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          check_field("read_data", want_rsp.read_data, rsp_i.read_data);
          check_field("read_valid", want_rsp.read_valid, rsp_i.read_valid);
          check_field("fetching", want_rsp.fetching, rsp_i.fetching);
          check_field("bus_read_address", want_rsp.bus_read_address, rsp_i.bus_read_address);
          check_field("bus_read_request", want_rsp.bus_read_request, rsp_i.bus_read_request);
          check_field("queue_count", want_rsp.queue_count, rsp_i.queue_count);
          check_field("queue_overflow", want_rsp.queue_overflow, rsp_i.queue_overflow);
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(predict_cache_response(req_i));
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ----- tb/sv/two_way_data_cache_controller_tb.sv -----
// Testbench top for the two-way data cache controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module two_way_data_cache_controller_tb;
  import twdcc_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1150;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WORDS         = WORDS_PER_LINE_DEF;
  localparam int unsigned WORD_W        = $clog2(WORDS);
  localparam int unsigned SET_W         = $clog2(SET_COUNT_DEF);
  localparam int unsigned LINE_W        = WORD_W + 2;
  localparam int unsigned TAG_W         = ADDR_BITS - LINE_W - SET_W;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  cache_req_t req_i;
  logic       rsp_valid_o;
  cache_rsp_t rsp_o;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          sent;
  int unsigned          cycle_cnt;
  cache_rsp_t           last_rsp;
  bit                   no_gaps;
  logic [ADDR_BITS-1:0] recent_line;
  logic [SET_W-1:0]     set_pool [16];
  logic [TAG_W-1:0]     tag_pool [3];

  two_way_data_cache_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  two_way_data_cache_controller_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .rsp_valid_i  (rsp_valid_o),
    .rsp_i        (rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Latest response, used to steer line fills
  always @(posedge clk_i) begin
    if (rsp_valid_o) last_rsp <= rsp_o;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("two_way_data_cache_controller verification failed");
    $finish;
  end

  function automatic cache_req_t mk_req(input op_e op, input logic [ADDR_BITS-1:0] addr,
                                        input logic [DATA_W-1:0] data, input logic last,
                                        input logic ack);
    cache_req_t r;
    r.opcode       = op;
    r.address      = addr;
    r.data         = data;
    r.fill_last    = last;
    r.bus_read_ack = ack;
    return r;
  endfunction

  function automatic logic rand_ack();
    return $urandom_range(0, 2) == 0;
  endfunction

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Address from the working set: the line just filled or a pooled set and tag
  function automatic logic [ADDR_BITS-1:0] pick_addr();
    logic [ADDR_BITS-1:0] a;
    a = ADDR_BITS'($urandom);
    if ($urandom_range(0, 1)) begin
      a[ADDR_BITS-1:LINE_W] = recent_line[ADDR_BITS-1:LINE_W];
    end else begin
      a[LINE_W +: SET_W]        = set_pool[$urandom_range(0, 15)];
      a[ADDR_BITS-1 -: TAG_W]   = tag_pool[$urandom_range(0, 2)];
    end
    return a;
  endfunction

  // Drive one transaction from a falling edge and hold it until accepted
  task automatic issue(input cache_req_t r);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      start_i <= 1'b0;
      req_i   <= cache_req_t'({$urandom, $urandom});
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Drop start so the held transaction is not taken again, then drain
  task automatic wait_results();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Deliver all words of a line, the final one flagged; optional ignored traffic between
  task automatic fill_line(input logic [ADDR_BITS-1:0] line_addr, input bit shuffled,
                           input bit noisy);
    int unsigned          order [WORDS];
    int unsigned          j;
    int unsigned          t;
    logic [ADDR_BITS-1:0] a;
    for (int k = 0; k < WORDS; k++) order[k] = k;
    if (shuffled) begin
      for (int k = WORDS - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        t        = order[k];
        order[k] = order[j];
        order[j] = t;
      end
    end
    for (int k = 0; k < WORDS; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        // cpu accesses are dropped while fetching; stray fills only overwrite data
        if ($urandom_range(0, 1))
          issue(mk_req($urandom_range(0, 1) ? OP_READ : OP_WRITE, pick_addr(), $urandom,
                       1'b0, rand_ack()));
        else
          issue(mk_req(OP_FILL, ADDR_BITS'($urandom), $urandom, 1'b0, rand_ack()));
        sent++;
      end
      a                 = line_addr;
      a[2 +: WORD_W]    = WORD_W'(order[k]);
      a[1:0]            = 2'($urandom_range(0, 3));
      issue(mk_req(OP_FILL, a, $urandom, k == WORDS - 1, rand_ack()));
      sent++;
    end
  endtask

  initial begin
    op_e                  op;
    int unsigned          burst;
    int unsigned          pick;
    logic [ADDR_BITS-1:0] line_addr;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    last_rsp    = '0;
    sent        = 0;
    no_gaps     = 1'b0;
    recent_line = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cold misses at both address extremes, hits, dirty queueing, ignored traffic
    issue(mk_req(OP_READ, '0, '0, 1'b0, 1'b0));
    issue(mk_req(OP_WRITE, '1, '0, 1'b1, 1'b0));
    fill_line('0, 1'b0, 1'b0);
    issue(mk_req(OP_READ, ADDR_BITS'('h1C), '1, 1'b0, 1'b1));
    issue(mk_req(OP_WRITE, ADDR_BITS'('h4), '1, 1'b0, 1'b0));
    issue(mk_req(OP_READ, ADDR_BITS'('h4), '0, 1'b0, 1'b0));
    // second write to a queued line adds nothing
    issue(mk_req(OP_WRITE, ADDR_BITS'('h8), '0, 1'b0, 1'b0));
    // write miss: the word is not stored
    issue(mk_req(OP_WRITE, '1, $urandom, 1'b0, 1'b0));
    fill_line({{(ADDR_BITS-LINE_W){1'b1}}, {LINE_W{1'b0}}}, 1'b1, 1'b0);
    issue(mk_req(OP_READ, '1, '0, 1'b0, 1'b1));
    // fill with nothing outstanding is dropped
    issue(mk_req(OP_FILL, '1, '1, 1'b1, 1'b1));
    sent = 25;

    set_pool[0] = '0;
    set_pool[1] = '1;
    for (int i = 2; i < 16; i++) set_pool[i] = SET_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'($urandom);

    // Random: bursts of cpu accesses, then a line fill whenever one is outstanding, else now and then a stray fill
    while (sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      burst   = $urandom_range(1, 4);
      repeat (burst) begin
        pick = $urandom_range(0, 9);
        op   = (pick == 0) ? OP_IDLE : ((pick < 5) ? OP_READ : OP_WRITE);
        issue(mk_req(op, pick_addr(), $urandom, 1'($urandom_range(0, 1)), rand_ack()));
        sent++;
      end
      wait_results();
      if (last_rsp.fetching) begin
        line_addr = last_rsp.bus_read_address;
        // now and then complete with another tag of the same set
        if ($urandom_range(0, 9) == 0)
          line_addr[ADDR_BITS-1 -: TAG_W] = tag_pool[$urandom_range(0, 2)];
        fill_line(line_addr, $urandom_range(0, 3) == 0, 1'b1);
        recent_line = line_addr;
      end else if ($urandom_range(0, 4) == 0) begin
        issue(mk_req(OP_FILL, ADDR_BITS'($urandom), $urandom, 1'($urandom_range(0, 1)),
                     rand_ack()));
        sent++;
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0)
      $display("two_way_data_cache_controller verification clean");
    else
      $display("two_way_data_cache_controller verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/twdcc_pkg.sv
rtl/core/twdcc_ram.sv
rtl/core/twdcc_ctrl.sv
rtl/core/twdcc_dp.sv
rtl/core/two_way_data_cache_controller.sv
tb/sv/two_way_data_cache_controller_checker.sv
tb/sv/two_way_data_cache_controller_tb.sv
